// ===== rtl/core/scd_pkg.sv =====
// scd_pkg: widths, constants and register codes for the stereo chorus delay.
// No dependencies; imported by the channel interfaces and stereo_chorus_delay.
package scd_pkg;

    // Line geometry and sample format
    localparam int DELAY_DEPTH = 1024;
    localparam int SAMPLE_BITS = 24;
    localparam int IDX_W       = $clog2(DELAY_DEPTH);
    localparam int CNT_W       = $clog2(DELAY_DEPTH + 1);
    localparam int MEM_AW      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 ** MEM_AW;

    // Register field widths
    localparam int BASE_W = 18;
    localparam int AMP_W  = 18;
    localparam int STEP_W = 15;
    localparam int FB_W   = 16;

    // Fixed point
    localparam int PHASE_W  = 18;     // Q1.16, holds +/-1.0
    localparam int FRAC_W   = 8;      // 1/256 sample delay units
    localparam int Q16_ONE  = 65536;
    localparam int MIX_GAIN = 23167;  // 0.707 in Q15

    // Total delay word: wide enough for base + offset and for the line limit
    localparam int TOT_W = (IDX_W + FRAC_W + 2 > BASE_W + 2) ? IDX_W + FRAC_W + 2 : BASE_W + 2;

    // Shared multiplier operand widths
    localparam int MUL_A_W = (SAMPLE_BITS + 1 > PHASE_W) ? SAMPLE_BITS + 1 : PHASE_W;
    localparam int MUL_B_W = AMP_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LFO_AMPLITUDE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LFO_STEP      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = CFG_IDX_W'(3);

    localparam logic [BASE_W-1:0] BASE_DELAY_RST    = BASE_W'(80282);
    localparam logic [AMP_W-1:0]  LFO_AMPLITUDE_RST = AMP_W'(72262);
    localparam logic [STEP_W-1:0] LFO_STEP_RST      = STEP_W'(2);
    localparam logic [FB_W-1:0]   FEEDBACK_GAIN_RST = FB_W'(6554);

endpackage

// ===== rtl/core/scd_in_if.sv =====
// scd_in_if: input sample channel (valid/ready, sample and channel tag).
// Depends on scd_pkg for the sample width.
interface scd_in_if import scd_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          channel;

    modport source (output valid, output sample_in, output channel, input ready);
    modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

// ===== rtl/core/scd_out_if.sv =====
// scd_out_if: output sample channel (valid/ready, mixed sample).
// Depends on scd_pkg for the sample width.
interface scd_out_if import scd_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/scd_cfg_if.sv =====
// scd_cfg_if: register write channel (valid/ready, register index, data).
// Depends on scd_pkg for index and data widths.
interface scd_cfg_if import scd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/scd_ram.sv =====
// scd_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module scd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/stereo_chorus_delay.sv =====
// stereo_chorus_delay: two-channel chorus, triangle LFO modulating an
// interpolated delay line. Depends on scd_pkg, scd_in_if, scd_out_if,
// scd_cfg_if and scd_ram.
//
//   port    | dir | payload                       | transfer when
//   --------+-----+-------------------------------+--------------------
//   i_in    | in  | sample_in (s24), channel (1)  | valid && ready
//   o_out   | out | sample_out (s24)              | valid && ready
//   i_cfg   | in  | index (8), data (18)          | valid && ready
//
// A sample is taken only while the sequencer is idle:
// a one-hot sequencer steps through one shared multiplier (four products)
// and two reads on the single read port of the delay RAM.
// Reset is synchronous; no clearing pass, a per-channel
// fill count masks line slots not yet written to zero.
// A finished result waits in the output register; the next sample is taken
// meanwhile and the sequencer holds in its last step until the slot frees.
// Configuration writes are always ready.
module stereo_chorus_delay import scd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scd_in_if.sink    i_in,
    scd_out_if.source o_out,
    scd_cfg_if.sink   i_cfg
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_LFO  = 14'b00000000000010,
        S_MDEL = 14'b00000000000100,
        S_TOT  = 14'b00000000001000,
        S_ADDR = 14'b00000000010000,
        S_RDA  = 14'b00000000100000,
        S_RDB  = 14'b00000001000000,
        S_INT  = 14'b00000010000000,
        S_MINT = 14'b00000100000000,
        S_WET  = 14'b00001000000000,
        S_MFB  = 14'b00010000000000,
        S_WR   = 14'b00100000000000,
        S_MMIX = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    localparam logic signed [PHASE_W:0]   PH_ONE = (PHASE_W + 1)'(Q16_ONE);
    localparam logic signed [PHASE_W:0]   PH_TWO = (PHASE_W + 1)'(2 * Q16_ONE);
    localparam logic signed [TOT_W-1:0]   MAX_TOT = TOT_W'((DELAY_DEPTH - 1) * (2 ** FRAC_W));
    localparam logic [IDX_W:0]            DEPTH_X = (IDX_W + 1)'(DELAY_DEPTH);
    localparam logic [CNT_W-1:0]          CNT_FULL = CNT_W'(DELAY_DEPTH);
    localparam logic [IDX_W-1:0]          IDX_LAST = IDX_W'(DELAY_DEPTH - 1);
    localparam logic signed [PROD_W-1:0]  HALF_8  = PROD_W'(2 ** (FRAC_W - 1));
    localparam logic signed [PROD_W-1:0]  HALF_15 = PROD_W'(2 ** 14);
    localparam logic signed [PROD_W-1:0]  HALF_16 = PROD_W'(2 ** 15);
    localparam logic signed [PROD_W-1:0]  SMAX =
        PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0]  SMIN = -SMAX - PROD_W'(1);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] c;
        c = v;
        if (v > SMAX) begin
            c = SMAX;
        end else if (v < SMIN) begin
            c = SMIN;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

    // Control state
    t_state              r_state, n_state;
    logic                r_out_valid;
    logic signed [PHASE_W-1:0] r_phase [2];
    logic [1:0]          r_fall;
    logic [IDX_W-1:0]    r_wp [2];
    logic [CNT_W-1:0]    r_cnt [2];
    logic [BASE_W-1:0]   r_base;
    logic [AMP_W-1:0]    r_amp;
    logic [STEP_W-1:0]   r_step;
    logic [FB_W-1:0]     r_fb;

    // Datapath
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_ch;
    logic signed [PHASE_W-1:0]     r_ph;
    logic [IDX_W-1:0]              r_n, r_ia, r_ib;
    logic [FRAC_W-1:0]             r_f;
    logic                          r_va, r_vb;
    logic signed [SAMPLE_BITS-1:0] r_a, r_b, r_wet, r_out;
    logic signed [SAMPLE_BITS:0]   r_sum;
    logic signed [PROD_W-1:0]      r_prod;

    logic in_xfer, cfg_xfer, out_free, mem_we;
    logic [MEM_AW-1:0]      mem_raddr, mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_rdata;
    logic signed [SAMPLE_BITS-1:0] rd_s;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out;

    // Triangle LFO step and reflection
    logic signed [PHASE_W:0] ph_cur, ph_step, ph_raw, ph_new;
    logic                    ph_flip;

    always_comb begin
        ph_cur  = {r_phase[r_ch][PHASE_W-1], r_phase[r_ch]};
        ph_step = {{(PHASE_W + 1 - STEP_W){1'b0}}, r_step};
        ph_raw  = r_fall[r_ch] ? ph_cur - ph_step : ph_cur + ph_step;
        ph_new  = ph_raw;
        ph_flip = 1'b0;
        if (ph_raw > PH_ONE) begin
            ph_new  = PH_TWO - ph_raw;
            ph_flip = 1'b1;
        end else if (ph_raw < -PH_ONE) begin
            ph_new  = -PH_TWO - ph_raw;
            ph_flip = 1'b1;
        end
    end

    // Shared multiplier operand select
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [SAMPLE_BITS:0]   diff;

    assign diff = {r_b[SAMPLE_BITS-1], r_b} - {r_a[SAMPLE_BITS-1], r_a};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MDEL: begin
                mul_a = {{(MUL_A_W - PHASE_W){r_ph[PHASE_W-1]}}, r_ph};
                mul_b = {{(MUL_B_W - AMP_W){1'b0}}, r_amp};
            end
            S_MINT: begin
                mul_a = {{(MUL_A_W - SAMPLE_BITS - 1){diff[SAMPLE_BITS]}}, diff};
                mul_b = {{(MUL_B_W - FRAC_W){1'b0}}, r_f};
            end
            S_MFB: begin
                mul_a = {{(MUL_A_W - SAMPLE_BITS){r_wet[SAMPLE_BITS-1]}}, r_wet};
                mul_b = {{(MUL_B_W - FB_W){1'b0}}, r_fb};
            end
            S_MMIX: begin
                mul_a = {{(MUL_A_W - SAMPLE_BITS - 1){r_sum[SAMPLE_BITS]}}, r_sum};
                mul_b = MUL_B_W'(MIX_GAIN);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounded (half up) product shifts
    logic signed [PROD_W-1:0] prod_r8, prod_r15, prod_r16;
    assign prod_r8  = (r_prod + HALF_8) >>> FRAC_W;
    assign prod_r15 = (r_prod + HALF_15) >>> 15;
    assign prod_r16 = (r_prod + HALF_16) >>> 16;

    // Total delay, clamped to the line
    logic signed [TOT_W-1:0] base_s, ofs, tot, tot_sat;
    always_comb begin
        base_s  = {{(TOT_W - BASE_W){1'b0}}, r_base};
        ofs     = prod_r16[TOT_W-1:0];
        tot     = base_s + ofs;
        tot_sat = tot;
        if (tot < 0) begin
            tot_sat = '0;
        end else if (tot > MAX_TOT) begin
            tot_sat = MAX_TOT;
        end
    end

    // Tap addresses and fill-count validity
    logic [IDX_W:0]    sum_a, sum_b, adr_a, adr_b;
    logic [CNT_W-1:0]  n_ext, cnt_cur;
    logic              va, vb;

    always_comb begin
        sum_a   = {1'b0, r_wp[r_ch]} + {1'b0, r_n};
        sum_b   = sum_a + (IDX_W + 1)'(1);
        adr_a   = (sum_a >= DEPTH_X) ? sum_a - DEPTH_X : sum_a;
        adr_b   = (sum_b >= DEPTH_X) ? sum_b - DEPTH_X : sum_b;
        n_ext   = CNT_W'(r_n);
        cnt_cur = r_cnt[r_ch];
        va      = (cnt_cur == CNT_FULL) || ((r_n != '0) && (n_ext <= cnt_cur));
        vb      = (n_ext + CNT_W'(1)) <= cnt_cur;
    end

    // Interpolation, write-back and mix
    logic signed [SAMPLE_BITS-1:0] interp, wet_new, wr_sat, y_sat;
    logic signed [PROD_W-1:0]      x_ext, wr_full;

    always_comb begin
        interp  = prod_r8[SAMPLE_BITS-1:0];
        wet_new = r_a + interp;
        x_ext   = {{(PROD_W - SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
        wr_full = x_ext + prod_r15;
        wr_sat  = sat_sample(wr_full);
        y_sat   = sat_sample(prod_r15);
    end

    // Delay RAM: left line in the lower half, right line in the upper half
    assign mem_we    = (r_state == S_WR);
    assign mem_waddr = {r_ch, r_wp[r_ch]};
    assign mem_raddr = (r_state == S_RDB) ? {r_ch, r_ib} : {r_ch, r_ia};
    assign rd_s      = mem_rdata;

    scd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_sat),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_xfer) n_state = S_LFO;
            S_LFO:   n_state = S_MDEL;
            S_MDEL:  n_state = S_TOT;
            S_TOT:   n_state = S_ADDR;
            S_ADDR:  n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_INT;
            S_INT:   n_state = S_MINT;
            S_MINT:  n_state = S_WET;
            S_WET:   n_state = S_MFB;
            S_MFB:   n_state = S_WR;
            S_WR:    n_state = S_MMIX;
            S_MMIX:  n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers, channel state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase[0]  <= '0;
            r_phase[1]  <= '0;
            r_fall      <= 2'b10;
            r_wp[0]     <= '0;
            r_wp[1]     <= '0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_base      <= BASE_DELAY_RST;
            r_amp       <= LFO_AMPLITUDE_RST;
            r_step      <= LFO_STEP_RST;
            r_fb        <= FEEDBACK_GAIN_RST;
        end else begin
            r_state <= n_state;

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_LFO) begin
                r_phase[r_ch] <= ph_new[PHASE_W-1:0];
                if (ph_flip) begin
                    r_fall[r_ch] <= !r_fall[r_ch];
                end
            end

            if (r_state == S_WR) begin
                r_wp[r_ch] <= (r_wp[r_ch] == '0) ? IDX_LAST : r_wp[r_ch] - IDX_W'(1);
                if (r_cnt[r_ch] != CNT_FULL) begin
                    r_cnt[r_ch] <= r_cnt[r_ch] + CNT_W'(1);
                end
            end

            if (cfg_xfer) begin
                case (i_cfg.index)
                    REG_BASE_DELAY:    r_base <= i_cfg.data[BASE_W-1:0];
                    REG_LFO_AMPLITUDE: r_amp  <= i_cfg.data[AMP_W-1:0];
                    REG_LFO_STEP:      r_step <= i_cfg.data[STEP_W-1:0];
                    REG_FEEDBACK_GAIN: r_fb   <= i_cfg.data[FB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_x  <= i_in.sample_in;
                    r_ch <= i_in.channel;
                end
            end
            S_LFO:  r_ph <= ph_new[PHASE_W-1:0];
            S_MDEL, S_MINT, S_MFB, S_MMIX: r_prod <= mul_a * mul_b;
            S_TOT: begin
                r_n <= tot_sat[IDX_W+FRAC_W-1:FRAC_W];
                r_f <= tot_sat[FRAC_W-1:0];
            end
            S_ADDR: begin
                r_ia <= adr_a[IDX_W-1:0];
                r_ib <= adr_b[IDX_W-1:0];
                r_va <= va;
                r_vb <= vb;
            end
            S_RDB:  r_a <= r_va ? rd_s : '0;
            S_INT:  r_b <= r_vb ? rd_s : '0;
            S_WET:  r_wet <= wet_new;
            S_WR:   r_sum <= {r_x[SAMPLE_BITS-1], r_x} + {r_wet[SAMPLE_BITS-1], r_wet};
            S_OUT: begin
                if (out_free) begin
                    r_out <= y_sat;
                end
            end
            default: ;
        endcase
    end

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CNT_FULL) && (r_cnt[1] <= CNT_FULL))
        else $error("fill count beyond line depth");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase[0] <= Q16_ONE) && (r_phase[0] >= -Q16_ONE) &&
        (r_phase[1] <= Q16_ONE) && (r_phase[1] >= -Q16_ONE))
        else $error("LFO phase outside +/-1.0");

    a_wp_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |=> (r_wp[r_ch] != $past(r_wp[r_ch])))
        else $error("write position did not step after a line write");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the final step");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp[0] <= IDX_LAST) && (r_wp[1] <= IDX_LAST))
        else $error("write position beyond line");

endmodule

// ===== tb/tb_stereo_chorus_delay.sv =====
// tb_stereo_chorus_delay: self-checking bench for the two-channel chorus delay line.
// Depends on scd_pkg, scd_in_if, scd_out_if, scd_cfg_if and stereo_chorus_delay.
// A bit-accurate chorus predictor in the bench checks every output transfer in order.
module tb_stereo_chorus_delay;
    import scd_pkg::*;

    localparam int    CLK_HALF     = 6;
    localparam int    RESET_CYCLES = 8;
    localparam int    SETTLE_WAIT  = 20;
    localparam int    CYCLE_LIMIT  = 300000;
    localparam longint SAMP_MAX    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMP_MIN    = -SAMP_MAX - 1;
    localparam longint DELAY_CAP   = longint'(DELAY_DEPTH - 1) * 256;

    // Register limits used for stimulus
    localparam int BASE_HI = 261888;
    localparam int AMP_HI  = 261888;
    localparam int STEP_HI = 16384;
    localparam int FB_HI   = 32768;

    logic i_clk;
    logic i_rst_n;

    scd_in_if  in_ch();
    scd_out_if out_ch();
    scd_cfg_if cfg_ch();

    stereo_chorus_delay DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state: one delay line, write pointer and LFO per channel
    logic signed [SAMPLE_BITS-1:0] line_mem [2][DELAY_DEPTH];
    longint                        wr_pos   [2];
    longint                        lfo_ph   [2];
    bit                            lfo_down [2];
    logic [BASE_W-1:0]             cfg_base;
    logic [AMP_W-1:0]              cfg_amp;
    logic [STEP_W-1:0]             cfg_step;
    logic [FB_W-1:0]               cfg_fb;

    logic signed [SAMPLE_BITS-1:0] mix_expected [$];

    int src_idle_pct;
    int sink_stall_pct;
    int cycle_count;
    int n_errors;
    int n_samples_sent;
    int n_results_checked;
    int n_reg_writes;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Round to nearest, ties toward +inf
    function automatic longint rnd_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip_sample(input longint v);
        if (v > SAMP_MAX) return SAMP_MAX;
        if (v < SAMP_MIN) return SAMP_MIN;
        return v;
    endfunction

    // One sample through the chorus: LFO step, interpolated read, feedback write, mix
    function automatic logic signed [SAMPLE_BITS-1:0] chorus_expect(
        input logic signed [SAMPLE_BITS-1:0] dry,
        input bit                            ch
    );
        longint x, ph, total, n, f, ia, ib, a, b, wet, wr, y, wp;
        x  = dry;
        ph = lfo_ph[ch] + (lfo_down[ch] ? -longint'(cfg_step) : longint'(cfg_step));
        // triangle reflection at +/-1.0 flips the direction
        if (ph > Q16_ONE) begin
            ph = 2 * longint'(Q16_ONE) - ph;
            lfo_down[ch] = !lfo_down[ch];
        end else if (ph < -Q16_ONE) begin
            ph = -2 * longint'(Q16_ONE) - ph;
            lfo_down[ch] = !lfo_down[ch];
        end
        lfo_ph[ch] = ph;

        wp    = wr_pos[ch];
        total = longint'(cfg_base) + rnd_half_up(ph * longint'(cfg_amp), 16);
        if (total < 0) total = 0;
        if (total > DELAY_CAP) total = DELAY_CAP;
        n  = total >>> FRAC_W;
        f  = total & 255;
        ia = (wp + n) % DELAY_DEPTH;
        ib = (ia + 1) % DELAY_DEPTH;
        a  = line_mem[ch][ia];
        b  = line_mem[ch][ib];
        wet = a + rnd_half_up((b - a) * f, FRAC_W);

        wr = clip_sample(x + rnd_half_up(wet * longint'(cfg_fb), 15));
        line_mem[ch][wp] = wr[SAMPLE_BITS-1:0];
        wr_pos[ch] = (wp == 0) ? DELAY_DEPTH - 1 : wp - 1;

        y = clip_sample(rnd_half_up((x + wet) * MIX_GAIN, 15));
        return y[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(
        input string                         what,
        input logic signed [SAMPLE_BITS-1:0] got,
        input logic signed [SAMPLE_BITS-1:0] want
    );
        $display("[%0d] MISMATCH %s: sample_out got %0d, want %0d",
                 cycle_count, what, got, want);
        n_errors++;
    endtask

    // Sample transfer; valid stays high afterwards so the next call can follow directly
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit ch);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        in_ch.channel   <= ch;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        mix_expected.push_back(chorus_expect(s, ch));
        n_samples_sent++;
    endtask

    // Register write; the model follows the masking of the register widths
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_BASE_DELAY:    cfg_base = val[BASE_W-1:0];
            REG_LFO_AMPLITUDE: cfg_amp  = val[AMP_W-1:0];
            REG_LFO_STEP:      cfg_step = val[STEP_W-1:0];
            REG_FEEDBACK_GAIN: cfg_fb   = val[FB_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        n_reg_writes++;
        @(posedge i_clk);
    endtask

    // Stop sending and let every pending result come out
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (mix_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return SAMP_MAX[SAMPLE_BITS-1:0];
            1:       return SAMP_MIN[SAMPLE_BITS-1:0];
            2:       return $urandom_range(1) ? '0 : '1;
            3, 4:    return SAMPLE_BITS'(int'($urandom_range(2000)) - 1000);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Register value: the limits, all ones, zero or something in range
    function automatic logic [CFG_DATA_W-1:0] rand_reg(input int lo, input int hi);
        case ($urandom_range(7))
            0:       return CFG_DATA_W'(lo);
            1:       return CFG_DATA_W'(hi);
            2:       return '1;
            3:       return '0;
            default: return CFG_DATA_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Reset settings, sample extremes and alternating bit patterns on both channels
    task automatic test_dry_extremes();
        send_sample(SAMP_MAX[SAMPLE_BITS-1:0], 1'b0);
        send_sample(SAMP_MIN[SAMPLE_BITS-1:0], 1'b1);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        send_sample(24'sh555555, 1'b0);
        send_sample(24'shAAAAAA, 1'b1);
        drain_results();
    endtask

    // Zero delay, negative total delay and a delay beyond the line
    task automatic test_delay_limits();
        write_reg(REG_BASE_DELAY, '0);
        write_reg(REG_LFO_AMPLITUDE, '0);
        send_sample(24'sh123456, 1'b0);
        send_sample(-24'sh0ABCDE, 1'b1);
        drain_results();
        // amplitude well beyond base: falling right channel drives the delay below zero
        write_reg(REG_BASE_DELAY, 18'd256);
        write_reg(REG_LFO_AMPLITUDE, CFG_DATA_W'(AMP_HI));
        write_reg(REG_LFO_STEP, CFG_DATA_W'(STEP_HI));
        send_sample(SAMP_MAX[SAMPLE_BITS-1:0], 1'b1);
        send_sample(SAMP_MIN[SAMPLE_BITS-1:0], 1'b1);
        send_sample(24'sh000777, 1'b0);
        send_sample(24'sh7FF000, 1'b1);
        drain_results();
        write_reg(REG_BASE_DELAY, CFG_DATA_W'(BASE_HI));
        send_sample(24'sh400000, 1'b0);
        send_sample(-24'sh400000, 1'b1);
        drain_results();
        write_reg(REG_BASE_DELAY, '1);
        send_sample(24'sh00FFFF, 1'b0);
        drain_results();
    endtask

    // Oversized step and feedback: fast reflections and saturating writes
    task automatic test_large_gains();
        write_reg(REG_BASE_DELAY, 18'd512);
        write_reg(REG_LFO_AMPLITUDE, 18'd256);
        write_reg(REG_LFO_STEP, 18'd32767);
        write_reg(REG_FEEDBACK_GAIN, 18'd65535);
        for (int i = 0; i < 6; i++)
            send_sample(i[0] ? SAMP_MIN[SAMPLE_BITS-1:0] : SAMP_MAX[SAMPLE_BITS-1:0], i[1]);
        drain_results();
    endtask

    // Stray indexes must be ignored, oversized data masked to the field width
    task automatic test_register_decode();
        write_reg(8'hFF, '0);
        write_reg(8'd4, '1);
        write_reg(REG_LFO_STEP, '1);
        write_reg(REG_FEEDBACK_GAIN, '1);
        write_reg(REG_LFO_AMPLITUDE, '1);
        write_reg(REG_BASE_DELAY, 18'h2AAAA);
        send_sample(24'sh3C3C3C, 1'b0);
        send_sample(-24'sh3C3C3C, 1'b1);
        send_sample(24'sh000001, 1'b0);
        drain_results();
    endtask

    // Random settings and samples under the four handshake pressure profiles
    task automatic test_random_traffic();
        int mode;
        bit ch;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 82; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            for (int sub = 0; sub < 3; sub++) begin
                write_reg(REG_BASE_DELAY, rand_reg(256, BASE_HI));
                write_reg(REG_LFO_AMPLITUDE, rand_reg(0, AMP_HI));
                write_reg(REG_LFO_STEP, rand_reg(0, STEP_HI));
                write_reg(REG_FEEDBACK_GAIN, rand_reg(0, FB_HI));
                if ($urandom_range(2) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(255, 4)), CFG_DATA_W'($urandom));
                // late in the run zero delay is tried again; neither line has wrapped yet
                if (ph == 3 && sub == 0) begin
                    write_reg(REG_BASE_DELAY, '0);
                    write_reg(REG_LFO_AMPLITUDE, '0);
                end
                mode = $urandom_range(2);
                for (int i = 0; i < 110; i++) begin
                    case (mode)
                        0:       ch = i[0];
                        1:       ch = 1'($urandom_range(1));
                        default: ch = ($urandom_range(9) == 0);
                    endcase
                    send_sample(rand_sample(), ch);
                end
                drain_results();
            end
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // Output ready, stalled at random
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Each output transfer against the oldest expected sample
    always @(posedge i_clk) begin : check_results
        logic signed [SAMPLE_BITS-1:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (mix_expected.size() == 0) begin
                report_mismatch("unexpected transfer", out_ch.sample_out, '0);
            end else begin
                want = mix_expected.pop_front();
                n_results_checked++;
                if (out_ch.sample_out !== want)
                    report_mismatch("mixed sample", out_ch.sample_out, want);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, mix_expected.size());
            $display("tb_stereo_chorus_delay failed");
            $finish;
        end
    end

    initial begin
        cycle_count       = 0;
        n_errors          = 0;
        n_samples_sent    = 0;
        n_results_checked = 0;
        n_reg_writes      = 0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.sample_in   = '0;
        in_ch.channel     = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;

        // predictor reset state: right LFO starts falling
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < DELAY_DEPTH; i++) line_mem[c][i] = '0;
            wr_pos[c]   = 0;
            lfo_ph[c]   = 0;
            lfo_down[c] = (c == 1);
        end
        cfg_base = BASE_DELAY_RST;
        cfg_amp  = LFO_AMPLITUDE_RST;
        cfg_step = LFO_STEP_RST;
        cfg_fb   = FEEDBACK_GAIN_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_dry_extremes();
        test_delay_limits();
        test_large_gains();
        test_register_decode();
        test_random_traffic();

        $display("run covered %0d samples in, %0d outputs checked, %0d register writes",
                 n_samples_sent, n_results_checked, n_reg_writes);
        $display("settings included zero, negative and clipped delays and oversized gains");
        if (n_errors == 0) begin
            $display("tb_stereo_chorus_delay passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("tb_stereo_chorus_delay failed");
        end
        $finish;
    end

endmodule
